// File: rtl/bfrq_pkg.sv
`timescale 1ns / 1ps
// Package for the boosted FIFO run queue.
// Holds default sizes, operation codes and the controller command struct.
package bfrq_pkg;

   // Default sizes handed to the top-level parameters
   localparam int QUEUE_DEPTH_DEF  = 64;
   localparam int TASK_ID_BITS_DEF = 16;

   // Operation codes on req_func; the fourth code is a no-op
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_PICK   = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;  // latch the request and register the match vector
      logic execute;  // apply the update and load the result register
   } ctl_cmd_type;

endpackage

// File: rtl/bfrq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the run queue: two-state sequencer and result valid flag.
// Depends on bfrq_pkg for the command struct.
module bfrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bfrq_pkg::ctl_cmd_type cmd
);
   import bfrq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new value when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall   = (state_ff != ST_IDLE);
   assign cmd.capture = req_valid && (state_ff == ST_IDLE);
   assign cmd.execute = (state_ff == ST_EXEC) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on execute, held while the consumer stalls
   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not move to execute");
   a_execute_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("execute did not present a result");
   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && !cmd.execute) |=> (state_ff == ST_EXEC))
      else $error("left execute without writing the result");
`endif

endmodule

// File: rtl/bfrq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the run queue: shifting entry array, parallel match vector,
// update logic and result register. Depends on bfrq_pkg.
module bfrq_datapath #(
   parameter int QUEUE_DEPTH  = bfrq_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = bfrq_pkg::TASK_ID_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bfrq_pkg::ctl_cmd_type              cmd,
   input  logic [1:0]                         req_func,
   input  logic [TASK_ID_BITS-1:0]            req_task_id,
   input  logic                               req_boost,
   output logic [TASK_ID_BITS-1:0]            rsp_picked_task,
   output logic                               rsp_picked_valid,
   output logic                               rsp_removed_found,
   output logic                               rsp_overflow,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_queue_length
);
   import bfrq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Queue entries, entry 0 is the front
   logic [TASK_ID_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] entry_in [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] left_nb  [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] right_nb [QUEUE_DEPTH];
   logic [CNT_W-1:0]        count_ff, count_in;

   // Latched request and match vector
   logic [1:0]              op_ff;
   logic [TASK_ID_BITS-1:0] task_ff;
   logic                    boost_ff;
   logic [QUEUE_DEPTH-1:0]  match_ff, match_in;

   // Result register
   logic [TASK_ID_BITS-1:0] picked_ff, picked_in;
   logic                    pvalid_ff, pvalid_in;
   logic                    found_ff, found_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        len_ff;

   logic [QUEUE_DEPTH-1:0]  valid_vec, last_vec, tail_vec;
   logic [QUEUE_DEPTH-1:0]  front_hits, shift_mask;
   logic                    last_hit, any_front, full, nonempty;

   // Per-entry neighbors, position decodes and compares
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign left_nb[g] = entry_ff[g];
      end else begin : g_mid
         assign left_nb[g] = entry_ff[g+1];
      end
      if (g == 0) begin : g_head
         assign right_nb[g] = task_ff;
      end else begin : g_body
         assign right_nb[g] = entry_ff[g-1];
      end
      assign valid_vec[g] = CNT_W'(g) < count_ff;
      assign last_vec[g]  = CNT_W'(g + 1) == count_ff;
      assign tail_vec[g]  = CNT_W'(g) == count_ff;
      assign match_in[g]  = entry_ff[g] == req_task_id;
   end

   // Remove search: last entry first, else frontmost hit among the others
   assign last_hit   = |(match_ff & last_vec);
   assign front_hits = match_ff & valid_vec & ~last_vec;
   assign any_front  = |front_hits;
   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign nonempty   = count_ff != '0;

   // Prefix OR marks the first hit and every entry behind it
   always_comb begin
      shift_mask = front_hits;
      for (int k = 1; k < QUEUE_DEPTH; k = k * 2) begin
         shift_mask = shift_mask | (shift_mask << k);
      end
   end

   // Queue update and result for the latched operation
   always_comb begin
      entry_in  = entry_ff;
      count_in  = count_ff;
      picked_in = '0;
      pvalid_in = 1'b0;
      found_in  = 1'b0;
      ovf_in    = 1'b0;
      case (op_ff)
         FUNC_ADD: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (boost_ff) entry_in[i] = right_nb[i];
                  else if (tail_vec[i]) entry_in[i] = task_ff;
               end
            end
         end
         FUNC_REMOVE: begin
            if (last_hit) begin
               found_in = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else if (any_front) begin
               found_in = 1'b1;
               count_in = count_ff - CNT_W'(1);
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (shift_mask[i]) entry_in[i] = left_nb[i];
               end
            end
         end
         FUNC_PICK: begin
            if (nonempty) begin
               picked_in = entry_ff[0];
               pvalid_in = 1'b1;
               count_in  = count_ff - CNT_W'(1);
               entry_in  = left_nb;
            end
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_func;
         task_ff  <= req_task_id;
         boost_ff <= req_boost;
         match_ff <= match_in;
      end
      if (cmd.execute) begin
         entry_ff  <= entry_in;
         picked_ff <= picked_in;
         pvalid_ff <= pvalid_in;
         found_ff  <= found_in;
         ovf_ff    <= ovf_in;
         len_ff    <= count_in;
      end
   end

   assign rsp_picked_task   = picked_ff;
   assign rsp_picked_valid  = pvalid_ff;
   assign rsp_removed_found = found_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_queue_length  = len_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (!ovf_ff || (len_ff == CNT_W'(QUEUE_DEPTH))))
      else $error("overflow reported on a queue that is not full");
   a_pick_pops: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (op_ff == FUNC_PICK) && nonempty)
      |=> (pvalid_ff && (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("pick did not pop one entry");
`endif

endmodule

// File: rtl/boosted_fifo_run_queue.sv
`timescale 1ns / 1ps
// Run queue of task IDs with front insertion on boost. A new request is not
// taken until the last one is executed: the parallel match vector is first
// registered, then the shift update over the entry registers is applied,
// which waits while the consumer stalls. Reset clears the entry count and
// both handshakes; entry contents are not cleared and need no clearing pass.
module boosted_fifo_run_queue #(
   parameter int QUEUE_DEPTH  = bfrq_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = bfrq_pkg::TASK_ID_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [TASK_ID_BITS-1:0]            req_task_id,
   input  logic                               req_boost,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [TASK_ID_BITS-1:0]            rsp_picked_task,
   output logic                               rsp_picked_valid,
   output logic                               rsp_removed_found,
   output logic                               rsp_overflow,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_queue_length
);
   import bfrq_pkg::*;

   ctl_cmd_type cmd;

   // Sequencer
   bfrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Queue storage and update
   bfrq_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_boost         (req_boost),
      .rsp_picked_task   (rsp_picked_task),
      .rsp_picked_valid  (rsp_picked_valid),
      .rsp_removed_found (rsp_removed_found),
      .rsp_overflow      (rsp_overflow),
      .rsp_queue_length  (rsp_queue_length)
   );

endmodule
